/* hw/rtl/dlm_pkg.sv */
`timescale 1ns / 1ps

package dlm_pkg;

    // Sizes
    localparam int NUM_DEVICES = 12;
    localparam int COUNT_BITS  = 8;
    localparam int TICK_W      = 8;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int DEV_W       = 4;
    localparam int MODE_W      = 2;
    localparam int GROUP_W     = 5;
    localparam int CMP_W       = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int NUM_MOTORS  = 10;
    localparam int IMU_DEV     = 10;
    localparam int REMOTE_DEV  = 11;

    // Stream packing
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = MODE_W;
    localparam int RESULT_W  = GROUP_W + NUM_DEVICES + 2;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Item kinds
    localparam logic [MODE_W-1:0] MODE_FRAME   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONITOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LED     = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMU_MIN_FRAMES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMU_CLEAR_ABOVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_FAST_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_SLOW_PERIOD = 3'd6;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_FAST_PERIOD     = 8'd5;
    localparam logic [CFG_W-1:0] RST_SLOW_PERIOD     = 8'd20;
    localparam logic [CFG_W-1:0] RST_MIN_FRAMES      = 8'd5;
    localparam logic [CFG_W-1:0] RST_IMU_MIN_FRAMES  = 8'd4;
    localparam logic [CFG_W-1:0] RST_IMU_CLEAR_ABOVE = 8'd2;
    localparam logic [CFG_W-1:0] RST_LED_FAST_PERIOD = 8'd30;
    localparam logic [CFG_W-1:0] RST_LED_SLOW_PERIOD = 8'd100;

    // Group bits
    localparam logic [GROUP_W-1:0] GRP_CHASSIS = 5'h01;
    localparam logic [GROUP_W-1:0] GRP_FEEDER  = 5'h02;
    localparam logic [GROUP_W-1:0] GRP_GIMBAL  = 5'h04;
    localparam logic [GROUP_W-1:0] GRP_IMU     = 5'h08;
    localparam logic [GROUP_W-1:0] GRP_REMOTE  = 5'h10;

    // Device membership of each group
    localparam logic [NUM_DEVICES-1:0] DEVS_CHASSIS = 12'h01F;
    localparam logic [NUM_DEVICES-1:0] DEVS_FEEDER  = 12'h060;
    localparam logic [NUM_DEVICES-1:0] DEVS_GIMBAL  = 12'h380;
    localparam logic [NUM_DEVICES-1:0] DEVS_IMU     = 12'h400;
    localparam logic [NUM_DEVICES-1:0] DEVS_REMOTE  = 12'h800;

    typedef logic [COUNT_BITS-1:0] count_t;
    localparam count_t COUNT_MAX = '1;

    typedef struct packed {
        logic [CFG_W-1:0] led_slow_period;
        logic [CFG_W-1:0] led_fast_period;
        logic [CFG_W-1:0] imu_clear_above;
        logic [CFG_W-1:0] imu_min_frames;
        logic [CFG_W-1:0] min_frames;
        logic [CFG_W-1:0] slow_period;
        logic [CFG_W-1:0] fast_period;
    } dlm_cfg_t;

    // Packed so that offline_groups sits in the lowest bits
    typedef struct packed {
        logic                   green_pin;
        logic                   red_pin;
        logic [NUM_DEVICES-1:0] device_offline;
        logic [GROUP_W-1:0]     offline_groups;
    } dlm_result_t;

    // Set a group bit when any device of the group is offline
    function automatic logic [GROUP_W-1:0] groups_of(input logic [NUM_DEVICES-1:0] flags);
        logic [GROUP_W-1:0] g;
        g = '0;
        if ((flags & DEVS_CHASSIS) != '0) g = g | GRP_CHASSIS;
        if ((flags & DEVS_FEEDER)  != '0) g = g | GRP_FEEDER;
        if ((flags & DEVS_GIMBAL)  != '0) g = g | GRP_GIMBAL;
        if ((flags & DEVS_IMU)     != '0) g = g | GRP_IMU;
        if ((flags & DEVS_REMOTE)  != '0) g = g | GRP_REMOTE;
        return g;
    endfunction

endpackage

/* hw/rtl/dlm_cfg.sv */
`timescale 1ns / 1ps

module dlm_cfg
    import dlm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output dlm_cfg_t             cfg
);

    dlm_cfg_t cfg_reg;
    dlm_cfg_t cfg_next;

    // Decode the write; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_FAST_PERIOD:     cfg_next.fast_period     = wr_data;
                CFG_SLOW_PERIOD:     cfg_next.slow_period     = wr_data;
                CFG_MIN_FRAMES:      cfg_next.min_frames      = wr_data;
                CFG_IMU_MIN_FRAMES:  cfg_next.imu_min_frames  = wr_data;
                CFG_IMU_CLEAR_ABOVE: cfg_next.imu_clear_above = wr_data;
                CFG_LED_FAST_PERIOD: cfg_next.led_fast_period = wr_data;
                CFG_LED_SLOW_PERIOD: cfg_next.led_slow_period = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_period     <= RST_FAST_PERIOD;
            cfg_reg.slow_period     <= RST_SLOW_PERIOD;
            cfg_reg.min_frames      <= RST_MIN_FRAMES;
            cfg_reg.imu_min_frames  <= RST_IMU_MIN_FRAMES;
            cfg_reg.imu_clear_above <= RST_IMU_CLEAR_ABOVE;
            cfg_reg.led_fast_period <= RST_LED_FAST_PERIOD;
            cfg_reg.led_slow_period <= RST_LED_SLOW_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/dlm_core.sv */
`timescale 1ns / 1ps

module dlm_core
    import dlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dlm_cfg_t          cfg,
    input  logic              step_valid,
    input  logic [MODE_W-1:0] step_mode,
    input  logic [DEV_W-1:0]  step_device,
    output dlm_result_t       result
);

    count_t                 count_reg [NUM_DEVICES];
    count_t                 count_next [NUM_DEVICES];
    logic [TICK_W-1:0]      fast_reg, fast_next;
    logic [TICK_W-1:0]      slow_reg, slow_next;
    logic [TICK_W-1:0]      blink_reg, blink_next;
    logic [NUM_DEVICES-1:0] flags_reg, flags_next;
    logic                   red_reg, red_next;
    logic                   green_reg, green_next;

    logic [TICK_W-1:0]      fast_inc, slow_inc, blink_inc;
    logic                   fast_fire, slow_fire, blink_fire;
    logic [GROUP_W-1:0]     groups_now;
    logic [CFG_W-1:0]       blink_limit;
    logic                   toggle_red;

    assign fast_inc   = fast_reg + TICK_W'(1);
    assign slow_inc   = slow_reg + TICK_W'(1);
    assign blink_inc  = blink_reg + TICK_W'(1);
    assign fast_fire  = fast_inc > cfg.fast_period;
    assign slow_fire  = slow_inc > cfg.slow_period;
    assign groups_now = groups_of(flags_reg);

    // Pick blink interval and which pin toggles from the group pattern
    always_comb
    begin
        if (groups_now == GRP_IMU)
        begin
            blink_limit = cfg.led_fast_period;
            toggle_red  = 1'b1;
        end
        else if (groups_now == GRP_REMOTE)
        begin
            blink_limit = cfg.led_fast_period;
            toggle_red  = 1'b0;
        end
        else if (groups_now == GRP_CHASSIS)
        begin
            blink_limit = cfg.led_slow_period;
            toggle_red  = 1'b1;
        end
        else
        begin
            blink_limit = cfg.led_slow_period;
            toggle_red  = 1'b0;
        end
    end

    assign blink_fire = blink_inc > blink_limit;

    // Apply one transaction to the state
    always_comb
    begin
        count_next = count_reg;
        fast_next  = fast_reg;
        slow_next  = slow_reg;
        blink_next = blink_reg;
        flags_next = flags_reg;
        red_next   = red_reg;
        green_next = green_reg;
        if (step_valid)
        begin
            case (step_mode)
                MODE_FRAME:
                begin
                    // Count the frame, saturating; unknown devices match nothing
                    for (int i = 0; i < NUM_DEVICES; i++)
                    begin
                        if (step_device == DEV_W'(i) && count_reg[i] != COUNT_MAX)
                        begin
                            count_next[i] = count_reg[i] + count_t'(1);
                        end
                    end
                end
                MODE_MONITOR:
                begin
                    fast_next = fast_inc;
                    slow_next = slow_inc;
                    // Fast window: check and clear the motors
                    if (fast_fire)
                    begin
                        for (int i = 0; i < NUM_MOTORS; i++)
                        begin
                            flags_next[i] = CMP_W'(count_reg[i]) < CMP_W'(cfg.min_frames);
                            count_next[i] = '0;
                        end
                        fast_next = '0;
                    end
                    // Slow window: IMU keeps a low count, remote always clears
                    if (slow_fire)
                    begin
                        flags_next[IMU_DEV] =
                            CMP_W'(count_reg[IMU_DEV]) < CMP_W'(cfg.imu_min_frames);
                        if (CMP_W'(count_reg[IMU_DEV]) > CMP_W'(cfg.imu_clear_above))
                        begin
                            count_next[IMU_DEV] = '0;
                        end
                        flags_next[REMOTE_DEV] =
                            CMP_W'(count_reg[REMOTE_DEV]) < CMP_W'(cfg.min_frames);
                        count_next[REMOTE_DEV] = '0;
                        slow_next = '0;
                    end
                end
                MODE_LED:
                begin
                    blink_next = blink_inc;
                    if (groups_now == '0)
                    begin
                        green_next = 1'b0;
                        blink_next = '0;
                    end
                    else if (blink_fire)
                    begin
                        if (toggle_red)
                        begin
                            green_next = 1'b1;
                            red_next   = ~red_reg;
                        end
                        else
                        begin
                            red_next   = 1'b1;
                            green_next = ~green_reg;
                        end
                        blink_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DEVICES; i++)
            begin
                count_reg[i] <= '0;
            end
            fast_reg  <= '0;
            slow_reg  <= '0;
            blink_reg <= '0;
            flags_reg <= '0;
            red_reg   <= 1'b1;
            green_reg <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            fast_reg  <= fast_next;
            slow_reg  <= slow_next;
            blink_reg <= blink_next;
            flags_reg <= flags_next;
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

    // Report the state after this transaction
    assign result.offline_groups = groups_of(flags_next);
    assign result.device_offline = flags_next;
    assign result.red_pin        = red_next;
    assign result.green_pin      = green_next;

endmodule

/* hw/rtl/device_liveness_monitor_top.sv */
`timescale 1ns / 1ps

// Device liveness monitor. Each input transaction is a frame arrival for one of twelve
// devices, a monitor tick or an LED tick (kind in s_tuser), and each produces exactly one
// output transaction with the offline group bits, the per-device offline flags and the
// red/green LED pin levels as they stand after it. One transaction is taken every clock
// cycle while m_tready does not stall the output register; the accepting edge loads the
// input register, then all state updates and the window compares for all twelve devices
// are done combinationally into the output register. While a result waits on m_tready,
// the input register accepts a new transaction only while it is empty. Registers are
// written through the cfg channel, which is always ready, and should be changed only
// while no transaction is in flight.

module device_liveness_monitor_top
    import dlm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [3:0] device, rest zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] mode
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [4:0] offline_groups, [16:5] device_offline,
                                            // [17] red_pin, [18] green_pin, rest zero
    // Register write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dlm_cfg_t          cfg;
    dlm_result_t       result;

    logic              in_valid_reg, in_valid_next;
    logic [MODE_W-1:0] in_mode_reg;
    logic [DEV_W-1:0]  in_device_reg;
    logic              out_valid_reg, out_valid_next;
    dlm_result_t       out_data_reg;
    logic              advance;
    logic              in_take;
    logic              step_valid;

    assign cfg_ready = 1'b1;

    dlm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the input register forward when the output register is free or draining
    assign advance    = !out_valid_reg || m_tready;
    assign s_tready   = !in_valid_reg || advance;
    assign in_take    = s_tvalid && s_tready;
    assign step_valid = in_valid_reg && advance;

    dlm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step_valid  (step_valid),
        .step_mode   (in_mode_reg),
        .step_device (in_device_reg),
        .result      (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg   <= s_tuser[MODE_W-1:0];
            in_device_reg <= s_tdata[DEV_W-1:0];
        end
        if (step_valid)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

    // Group bits always follow the reported device flags
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_data_reg.offline_groups == groups_of(out_data_reg.device_offline))
        else $error("offline_groups does not match device_offline");

    // An empty input register never stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while input register is empty");

    // Every processed transaction lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        step_valid |=> out_valid_reg)
        else $error("processed transaction produced no result");

    // A stalled transaction stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_mode_reg)
            && $stable(in_device_reg))
        else $error("stalled transaction lost");

endmodule
